/* src/half_edge_connectivity_builder_macros.svh */
// Assertion macros for the half-edge connectivity builder
`ifndef HALF_EDGE_CONNECTIVITY_BUILDER_MACROS_SVH
`define HALF_EDGE_CONNECTIVITY_BUILDER_MACROS_SVH

// same-cycle implication, reset gated
`define HECB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hecb: same-cycle check failed");

// next-cycle implication, reset gated
`define HECB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hecb: next-cycle check failed");

`endif

/* src/hecb_pkg.sv */
// Shared types, constants and helpers for the half-edge connectivity builder
`default_nettype none

package hecb_pkg;

  localparam int MAX_EDGES_DEF      = 4096;
  localparam int MAX_HALF_EDGES_DEF = 8192;
  localparam int VERTEX_BITS_DEF    = 16;
  localparam int MAX_VALENCY_DEF    = 16;

  // fixed field widths of the record channel
  localparam int HE_W      = 13;
  localparam int FACE_W    = 13;
  localparam int EDGE_W    = 12;
  localparam int TWIN_W    = 14;
  localparam int TOTAL_W   = 13;
  localparam int VAL_IN_W  = 5;
  localparam int VAL_CMP_W = 7;

  localparam logic OP_CORNER = 1'b0;
  localparam logic OP_CLEAR  = 1'b1;

  localparam logic REC_NEW  = 1'b0;
  localparam logic REC_TWIN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_TWIN
  } hecb_state_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic scan_en;
    logic commit;
    logic emit_twin;
  } hecb_cmd_t;

  typedef struct packed {
    logic op_clear;
    logic edges_empty;
    logic scan_hit;
    logic scan_miss;
    logic out_free;
    logic twin_needed;
  } hecb_sts_t;

  // zero counts as one, anything above the limit counts as the limit
  function automatic logic [VAL_CMP_W-1:0] clamp_valency(
    input logic [VAL_IN_W-1:0]  v,
    input logic [VAL_CMP_W-1:0] max_v
  );
    logic [VAL_CMP_W-1:0] ext;
    ext = VAL_CMP_W'(v);
    if (ext == '0) begin
      ext = VAL_CMP_W'(1);
    end
    if (ext > max_v) begin
      ext = max_v;
    end
    return ext;
  endfunction

endpackage

`default_nettype wire

/* src/hecb_ifs.sv */
// Valid/ready channel interfaces for corners in and half-edge records out
`default_nettype none

interface hecb_corner_if #(
  parameter int VERTEX_BITS = hecb_pkg::VERTEX_BITS_DEF
);
  import hecb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic                   opcode;
  logic [VERTEX_BITS-1:0] origin_vertex;
  logic [VERTEX_BITS-1:0] target_vertex;
  logic [VAL_IN_W-1:0]    face_valency;

  modport source (
    output valid, opcode, origin_vertex, target_vertex, face_valency,
    input  ready
  );
  modport sink (
    input  valid, opcode, origin_vertex, target_vertex, face_valency,
    output ready
  );
endinterface

interface hecb_record_if #(
  parameter int VERTEX_BITS = hecb_pkg::VERTEX_BITS_DEF
);
  import hecb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     record_kind;
  logic [HE_W-1:0]          half_edge_index;
  logic [FACE_W-1:0]        face_index;
  logic [VERTEX_BITS-1:0]   vertex_index;
  logic [HE_W-1:0]          prev_half_edge;
  logic [HE_W-1:0]          next_half_edge;
  logic [EDGE_W-1:0]        edge_index;
  logic signed [TWIN_W-1:0] twin_half_edge;
  logic [TOTAL_W-1:0]       edge_total;
  logic                     table_full;
  logic                     last;

  modport source (
    output valid, record_kind, half_edge_index, face_index, vertex_index,
           prev_half_edge, next_half_edge, edge_index, twin_half_edge,
           edge_total, table_full, last,
    input  ready
  );
  modport sink (
    input  valid, record_kind, half_edge_index, face_index, vertex_index,
           prev_half_edge, next_half_edge, edge_index, twin_half_edge,
           edge_total, table_full, last,
    output ready
  );
endinterface

`default_nettype wire

/* src/half_edge_connectivity_builder.sv */
// Flow: a corner is captured, the edge table is scanned through its registered read port
//   (skipped when the table is empty; a hit ends the scan early), then the record is loaded.
// Throughput: sequential; the next corner is taken once the record is loaded, after the twin
//   update for a hit, and an output stall holds it back; a clear is done in the idle state.
// Reset: asynchronous, active low; counters cleared at once, edge table not cleared.
`default_nettype none
`include "half_edge_connectivity_builder_macros.svh"

module half_edge_connectivity_builder #(
  parameter int MAX_EDGES      = hecb_pkg::MAX_EDGES_DEF,
  parameter int MAX_HALF_EDGES = hecb_pkg::MAX_HALF_EDGES_DEF,
  parameter int VERTEX_BITS    = hecb_pkg::VERTEX_BITS_DEF,
  parameter int MAX_VALENCY    = hecb_pkg::MAX_VALENCY_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  hecb_corner_if.sink  corner_i,
  hecb_record_if.source record_o
);
  import hecb_pkg::*;

  hecb_cmd_t cmd;
  hecb_sts_t sts;

  hecb_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (corner_i.valid),
    .in_ready_o (corner_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hecb_datapath #(
    .MAX_EDGES      (MAX_EDGES),
    .MAX_HALF_EDGES (MAX_HALF_EDGES),
    .VERTEX_BITS    (VERTEX_BITS),
    .MAX_VALENCY    (MAX_VALENCY)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .opcode_i          (corner_i.opcode),
    .origin_vertex_i   (corner_i.origin_vertex),
    .target_vertex_i   (corner_i.target_vertex),
    .face_valency_i    (corner_i.face_valency),
    .out_valid_o       (record_o.valid),
    .out_ready_i       (record_o.ready),
    .record_kind_o     (record_o.record_kind),
    .half_edge_index_o (record_o.half_edge_index),
    .face_index_o      (record_o.face_index),
    .vertex_index_o    (record_o.vertex_index),
    .prev_half_edge_o  (record_o.prev_half_edge),
    .next_half_edge_o  (record_o.next_half_edge),
    .edge_index_o      (record_o.edge_index),
    .twin_half_edge_o  (record_o.twin_half_edge),
    .edge_total_o      (record_o.edge_total),
    .table_full_o      (record_o.table_full),
    .last_o            (record_o.last)
  );

  // overflow transaction is always the only one of its corner
  `HECB_ASSERT_IMP(a_full_is_last, clk_i, rst_ni, record_o.valid && record_o.table_full, record_o.last)

  // a twin update is never an overflow and always closes the corner
  `HECB_ASSERT_IMP(a_twin_closes, clk_i, rst_ni, record_o.valid && record_o.record_kind == REC_TWIN, record_o.last && !record_o.table_full)

  // once the first record of a hit is taken, its twin update is on the port
  `HECB_ASSERT_NXT(a_twin_follows, clk_i, rst_ni, record_o.valid && record_o.ready && !record_o.last, record_o.valid && record_o.record_kind == REC_TWIN)

  // the controller never commits and emits a twin in the same cycle
  `HECB_ASSERT_IMP(a_one_load, clk_i, rst_ni, cmd.commit, !cmd.emit_twin && !cmd.scan_en)

endmodule

`default_nettype wire

/* src/hecb_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port
`default_nettype none

module hecb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* src/hecb_ctrl.sv */
// Controller state machine: accept, edge table scan, commit, twin emission
`default_nettype none

module hecb_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  hecb_pkg::hecb_sts_t sts_i,
  output hecb_pkg::hecb_cmd_t cmd_o
);
  import hecb_pkg::*;

  hecb_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !sts_i.op_clear) begin
          state_d = sts_i.edges_empty ? ST_COMMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_hit || sts_i.scan_miss) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.twin_needed ? ST_TWIN : ST_IDLE;
        end
      end
      ST_TWIN: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i && !sts_i.op_clear;
        cmd_o.clear   = in_valid_i && sts_i.op_clear;
      end
      ST_SCAN: begin
        cmd_o.scan_en = 1'b1;
      end
      ST_COMMIT: begin
        cmd_o.commit = sts_i.out_free;
      end
      ST_TWIN: begin
        cmd_o.emit_twin = sts_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

/* src/hecb_datapath.sv */
// Datapath: corner capture, edge table and its scan, counters, output register
`default_nettype none

module hecb_datapath #(
  parameter int MAX_EDGES      = hecb_pkg::MAX_EDGES_DEF,
  parameter int MAX_HALF_EDGES = hecb_pkg::MAX_HALF_EDGES_DEF,
  parameter int VERTEX_BITS    = hecb_pkg::VERTEX_BITS_DEF,
  parameter int MAX_VALENCY    = hecb_pkg::MAX_VALENCY_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  hecb_pkg::hecb_cmd_t              cmd_i,
  output hecb_pkg::hecb_sts_t              sts_o,
  input  logic                             opcode_i,
  input  logic [VERTEX_BITS-1:0]           origin_vertex_i,
  input  logic [VERTEX_BITS-1:0]           target_vertex_i,
  input  logic [hecb_pkg::VAL_IN_W-1:0]    face_valency_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic                             record_kind_o,
  output logic [hecb_pkg::HE_W-1:0]        half_edge_index_o,
  output logic [hecb_pkg::FACE_W-1:0]      face_index_o,
  output logic [VERTEX_BITS-1:0]           vertex_index_o,
  output logic [hecb_pkg::HE_W-1:0]        prev_half_edge_o,
  output logic [hecb_pkg::HE_W-1:0]        next_half_edge_o,
  output logic [hecb_pkg::EDGE_W-1:0]      edge_index_o,
  output logic signed [hecb_pkg::TWIN_W-1:0] twin_half_edge_o,
  output logic [hecb_pkg::TOTAL_W-1:0]     edge_total_o,
  output logic                             table_full_o,
  output logic                             last_o
);
  import hecb_pkg::*;

  localparam int EAW = $clog2(MAX_EDGES);
  localparam int ECW = EAW + 1;
  localparam int HIW = $clog2(MAX_HALF_EDGES);
  localparam int HCW = HIW + 1;
  localparam int PW  = $clog2(MAX_VALENCY);
  localparam int SW  = $clog2(MAX_VALENCY + 1);
  localparam int CW  = SW + 1;
  localparam int RW  = 2 * VERTEX_BITS + HIW;

  // captured corner
  logic [VERTEX_BITS-1:0] lo_q, hi_q, org_q;
  logic [SW-1:0]          val_q;

  // scan
  logic [ECW-1:0] issue_q;
  logic           rd_vld_q;
  logic [EAW-1:0] rd_addr_q;
  logic           hit_q;
  logic [EAW-1:0] e_q;
  logic [HIW-1:0] t_q;
  logic [HIW-1:0] twin_h_q;

  // mesh counters
  logic [ECW-1:0]    ecnt_q;
  logic [HCW-1:0]    hcnt_q;
  logic [FACE_W-1:0] face_q;
  logic [PW-1:0]     pos_q;
  logic [SW-1:0]     size_q;

  // output register
  logic                     out_valid_q;
  logic                     kind_q;
  logic [HE_W-1:0]          he_q;
  logic [FACE_W-1:0]        fidx_q;
  logic [VERTEX_BITS-1:0]   vert_q;
  logic [HE_W-1:0]          prev_q;
  logic [HE_W-1:0]          next_q;
  logic [EDGE_W-1:0]        eidx_q;
  logic [TWIN_W-1:0]        twin_q;
  logic [TOTAL_W-1:0]       total_q;
  logic                     full_q;
  logic                     last_q;

  logic [RW-1:0]          rdata;
  logic [VERTEX_BITS-1:0] r_lo, r_hi;
  logic [HIW-1:0]         r_first;
  logic                   match;
  logic                   issue_ok;
  logic                   full;
  logic [SW-1:0]          eff_val;
  logic [HCW-1:0]         start_he, prev_he, next_he;
  logic                   wrap_end;
  logic [EAW-1:0]         e_sel;
  logic                   ram_we;
  logic [VERTEX_BITS-1:0] in_lo, in_hi;

  assign in_lo = (origin_vertex_i < target_vertex_i) ? origin_vertex_i : target_vertex_i;
  assign in_hi = (origin_vertex_i < target_vertex_i) ? target_vertex_i : origin_vertex_i;

  assign r_lo    = rdata[RW-1 -: VERTEX_BITS];
  assign r_hi    = rdata[HIW +: VERTEX_BITS];
  assign r_first = rdata[HIW-1:0];

  assign match    = rd_vld_q && (r_lo == lo_q) && (r_hi == hi_q);
  assign issue_ok = issue_q < ecnt_q;

  assign full = (hcnt_q >= HCW'(MAX_HALF_EDGES)) ||
                (!hit_q && (ecnt_q >= ECW'(MAX_EDGES)));

  // valency is latched at the first corner of a face
  assign eff_val  = (pos_q == '0) ? val_q : size_q;
  assign start_he = hcnt_q - HCW'(pos_q);
  assign prev_he  = (pos_q == '0) ? (start_he + HCW'(eff_val) - HCW'(1))
                                  : (hcnt_q - HCW'(1));
  assign wrap_end = (CW'(pos_q) + CW'(1)) >= CW'(eff_val);
  assign next_he  = wrap_end ? start_he : (hcnt_q + HCW'(1));
  assign e_sel    = hit_q ? e_q : ecnt_q[EAW-1:0];

  assign ram_we = cmd_i.commit && !full && !hit_q;

  hecb_ram #(
    .WIDTH (RW),
    .DEPTH (MAX_EDGES)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ecnt_q[EAW-1:0]),
    .wdata_i ({lo_q, hi_q, hcnt_q[HIW-1:0]}),
    .re_i    (cmd_i.scan_en && issue_ok),
    .raddr_i (issue_q[EAW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    sts_o.op_clear    = (opcode_i == OP_CLEAR);
    sts_o.edges_empty = (ecnt_q == '0);
    sts_o.scan_hit    = match;
    sts_o.scan_miss   = rd_vld_q && !match &&
                        ((ECW'(rd_addr_q) + ECW'(1)) == ecnt_q);
    sts_o.out_free    = !out_valid_q || out_ready_i;
    sts_o.twin_needed = hit_q && !full;
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ecnt_q      <= '0;
      hcnt_q      <= '0;
      face_q      <= '0;
      pos_q       <= '0;
      size_q      <= '0;
      issue_q     <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_en && issue_ok;
      if (cmd_i.capture) begin
        issue_q <= '0;
        hit_q   <= 1'b0;
      end else if (cmd_i.scan_en) begin
        if (issue_ok) begin
          issue_q <= issue_q + ECW'(1);
        end
        if (match) begin
          hit_q <= 1'b1;
        end
      end

      if (cmd_i.clear) begin
        ecnt_q <= '0;
        hcnt_q <= '0;
        face_q <= '0;
        pos_q  <= '0;
        size_q <= '0;
      end else if (cmd_i.commit && !full) begin
        if (!hit_q) begin
          ecnt_q <= ecnt_q + ECW'(1);
        end
        hcnt_q <= hcnt_q + HCW'(1);
        size_q <= eff_val;
        if (wrap_end) begin
          pos_q  <= '0;
          face_q <= face_q + FACE_W'(1);
        end else begin
          pos_q <= pos_q + PW'(1);
        end
      end

      if (cmd_i.commit || cmd_i.emit_twin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      lo_q  <= in_lo;
      hi_q  <= in_hi;
      org_q <= origin_vertex_i;
      val_q <= SW'(clamp_valency(face_valency_i, VAL_CMP_W'(MAX_VALENCY)));
    end
    if (cmd_i.scan_en && issue_ok) begin
      rd_addr_q <= issue_q[EAW-1:0];
    end
    if (cmd_i.scan_en && match) begin
      e_q <= rd_addr_q;
      t_q <= r_first;
    end
    if (cmd_i.commit) begin
      twin_h_q <= hcnt_q[HIW-1:0];
      if (full) begin
        kind_q  <= REC_NEW;
        he_q    <= '0;
        fidx_q  <= '0;
        vert_q  <= '0;
        prev_q  <= '0;
        next_q  <= '0;
        eidx_q  <= '0;
        twin_q  <= '0;
        total_q <= TOTAL_W'(ecnt_q);
        full_q  <= 1'b1;
        last_q  <= 1'b1;
      end else begin
        kind_q  <= REC_NEW;
        he_q    <= HE_W'(hcnt_q);
        fidx_q  <= face_q;
        vert_q  <= org_q;
        prev_q  <= HE_W'(prev_he);
        next_q  <= HE_W'(next_he);
        eidx_q  <= EDGE_W'(e_sel);
        twin_q  <= hit_q ? TWIN_W'(t_q) : '1;
        total_q <= hit_q ? TOTAL_W'(ecnt_q) : TOTAL_W'(ecnt_q + ECW'(1));
        full_q  <= 1'b0;
        last_q  <= !hit_q;
      end
    end else if (cmd_i.emit_twin) begin
      kind_q  <= REC_TWIN;
      he_q    <= HE_W'(t_q);
      fidx_q  <= '0;
      vert_q  <= '0;
      prev_q  <= '0;
      next_q  <= '0;
      eidx_q  <= EDGE_W'(e_q);
      twin_q  <= TWIN_W'(twin_h_q);
      total_q <= TOTAL_W'(ecnt_q);
      full_q  <= 1'b0;
      last_q  <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign record_kind_o     = kind_q;
  assign half_edge_index_o = he_q;
  assign face_index_o      = fidx_q;
  assign vertex_index_o    = vert_q;
  assign prev_half_edge_o  = prev_q;
  assign next_half_edge_o  = next_q;
  assign edge_index_o      = eidx_q;
  assign twin_half_edge_o  = twin_q;
  assign edge_total_o      = total_q;
  assign table_full_o      = full_q;
  assign last_o            = last_q;

endmodule

`default_nettype wire
